FILE: design/mscc_pkg.sv
// shared types, opcodes and helpers for the sixteen-bit multicycle core
package mscc_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned NumReg = 8;
  localparam int unsigned RegIdxW = $clog2(NumReg);

  localparam logic [RegIdxW-1:0] SpIdx    = RegIdxW'(7);
  localparam logic [RegIdxW-1:0] MulHiIdx = RegIdxW'(3);

  typedef enum logic [3:0] {
    PH_FETCH = 4'b0001,
    PH_WAIT  = 4'b0010,
    PH_EXEC  = 4'b0100,
    PH_CONTD = 4'b1000
  } phase_e;

  typedef enum logic [5:0] {
    OP_LDI  = 6'd0,
    OP_ST   = 6'd1,
    OP_LD   = 6'd2,
    OP_ADD  = 6'd3,
    OP_SUB  = 6'd4,
    OP_MUL  = 6'd5,
    OP_JMP  = 6'd6,
    OP_XCHG = 6'd7,
    OP_XOR  = 6'd8,
    OP_AND  = 6'd9,
    OP_OR   = 6'd10,
    OP_CMP  = 6'd11,
    OP_STI  = 6'd12,
    OP_SHL  = 6'd13,
    OP_SHR  = 6'd14,
    OP_MOV  = 6'd15,
    OP_INC  = 6'd16,
    OP_DEC  = 6'd17,
    OP_PSHI = 6'd18,
    OP_PSH  = 6'd19,
    OP_POP  = 6'd20,
    OP_DBG  = 6'd21
  } op_e;

  typedef enum logic [3:0] {
    JC_ALWAYS = 4'd0,
    JC_CARRY  = 4'd1,
    JC_LT     = 4'd4,
    JC_LE     = 4'd5,
    JC_GT     = 4'd8,
    JC_GE     = 4'd9,
    JC_EQ     = 4'd14,
    JC_NE     = 4'd15
  } jcond_e;

  // register file write request: extra port first, then dst, then src wins
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] dst_idx;
    logic [WordW-1:0]   dst_val;
    logic [RegIdxW-1:0] src_idx;
    logic [WordW-1:0]   src_val;
    logic               xtra_en;
    logic [RegIdxW-1:0] xtra_idx;
    logic [WordW-1:0]   xtra_val;
  } rf_wr_t;

  typedef struct packed {
    logic [WordW-1:0]   dv;
    logic [WordW-1:0]   sv;
    logic               carry_we;
    logic               carry;
    logic               cmp_zero;
    logic               cmp_sign;
    logic [2*WordW-1:0] product;
  } alu_res_t;

  function automatic logic jump_ok(logic [3:0] code, logic zf, logic sf, logic cf);
    logic ok;
    ok = 1'b0;
    unique case (jcond_e'(code))
      JC_ALWAYS: ok = 1'b1;
      JC_CARRY:  ok = cf;
      JC_LT:     ok = sf;
      JC_LE:     ok = sf | zf;
      JC_GT:     ok = ~sf & ~zf;
      JC_GE:     ok = ~sf;
      JC_EQ:     ok = zf;
      JC_NE:     ok = ~zf;
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: design/mscc_regfile.sv
// eight-entry register file with two read ports, a stack pointer output and an ordered write-back
module mscc_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mscc_pkg::rf_wr_t              wr_i,
  input  logic [mscc_pkg::RegIdxW-1:0]  rd_a_idx_i,
  input  logic [mscc_pkg::RegIdxW-1:0]  rd_b_idx_i,
  output logic [mscc_pkg::WordW-1:0]    rd_a_o,
  output logic [mscc_pkg::WordW-1:0]    rd_b_o,
  output logic [mscc_pkg::WordW-1:0]    sp_o
);
  import mscc_pkg::*;

  logic [WordW-1:0] regs_q [NumReg];
  logic [WordW-1:0] regs_d [NumReg];

  always_comb begin
    for (int i = 0; i < NumReg; i++) begin
      regs_d[i] = regs_q[i];
      if (wr_i.xtra_en && wr_i.xtra_idx == RegIdxW'(i)) regs_d[i] = wr_i.xtra_val;
      if (wr_i.en && wr_i.dst_idx == RegIdxW'(i)) regs_d[i] = wr_i.dst_val;
      if (wr_i.en && wr_i.src_idx == RegIdxW'(i)) regs_d[i] = wr_i.src_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumReg; i++) regs_q[i] <= '0;
    end else begin
      for (int i = 0; i < NumReg; i++) regs_q[i] <= regs_d[i];
    end
  end

  assign rd_a_o = regs_q[rd_a_idx_i];
  assign rd_b_o = regs_q[rd_b_idx_i];
  assign sp_o   = regs_q[SpIdx];

endmodule

FILE: design/mscc_alu.sv
// data path of the execute phase: logic ops, add/sub, compare, inc/dec, shifts, moves, exchange, multiply
module mscc_alu (
  input  logic [5:0]                 op_i,
  input  logic [4:0]                 shamt_i,
  input  logic [mscc_pkg::WordW-1:0] dv_i,
  input  logic [mscc_pkg::WordW-1:0] sv_i,
  output mscc_pkg::alu_res_t         res_o
);
  import mscc_pkg::*;

  logic [WordW:0] sum;
  logic [WordW:0] diff;
  logic [WordW:0] incr;
  logic [WordW:0] decr;

  assign sum  = {1'b0, dv_i} + {1'b0, sv_i};
  assign diff = {1'b0, dv_i} - {1'b0, sv_i};
  assign incr = {1'b0, dv_i} + (WordW+1)'(1);
  assign decr = {1'b0, dv_i} - (WordW+1)'(1);

  always_comb begin
    res_o          = '0;
    res_o.dv       = dv_i;
    res_o.sv       = sv_i;
    res_o.cmp_zero = (diff[WordW-1:0] == '0);
    res_o.cmp_sign = diff[WordW-1];
    res_o.product  = {{WordW{1'b0}}, dv_i} * {{WordW{1'b0}}, sv_i};
    unique case (op_e'(op_i))
      OP_ADD: begin
        res_o.dv = sum[WordW-1:0];
        res_o.carry_we = 1'b1;
        res_o.carry = sum[WordW];
      end
      OP_SUB, OP_CMP: begin
        if (op_e'(op_i) == OP_SUB) res_o.dv = diff[WordW-1:0];
        res_o.carry_we = 1'b1;
        res_o.carry = diff[WordW];
      end
      OP_MUL: begin
        res_o.carry_we = 1'b1;
        res_o.carry = 1'b0;
      end
      OP_XCHG: begin
        res_o.dv = sv_i;
        res_o.sv = dv_i;
      end
      OP_XOR: res_o.dv = dv_i ^ sv_i;
      OP_AND: res_o.dv = dv_i & sv_i;
      OP_OR:  res_o.dv = dv_i | sv_i;
      // counts of sixteen and up clear the word
      OP_SHL: res_o.dv = shamt_i[4] ? '0 : (dv_i << shamt_i[3:0]);
      OP_SHR: res_o.dv = shamt_i[4] ? '0 : (dv_i >> shamt_i[3:0]);
      OP_MOV: res_o.dv = sv_i;
      OP_INC: begin
        res_o.dv = incr[WordW-1:0];
        res_o.carry_we = 1'b1;
        res_o.carry = incr[WordW];
      end
      OP_DEC: begin
        res_o.dv = decr[WordW-1:0];
        res_o.carry_we = 1'b1;
        res_o.carry = decr[WordW];
      end
      default: ;
    endcase
  end

endmodule

FILE: design/multicycle_sixteen_bit_cpu_core.sv
// Sixteen-bit multicycle core stepped one clock tick per input item. Each input item carries the
// memory read word for the tick and produces exactly one result item: the memory request (address,
// write data, write enable) and the halt flag as they stand after that tick. An item is accepted
// in every cycle while the result register is empty or being drained, so the rate is one item per
// clock; the longest path is a register file read, then the 16x16 multiplier into the product
// register or the adder into the register file and flags. Results come out in the cycle after
// their item is accepted.
module multicycle_sixteen_bit_cpu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // mem_rdata[15:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // mem_addr[15:0], mem_wdata[31:16], mem_we[32],
                                        // halted_bad_opcode[33], zero pad[39:34]
);
  import mscc_pkg::*;

  phase_e             phase_q, phase_d;
  phase_e             after_q, after_d;
  logic [WordW-1:0]   ip_q, ip_d;
  logic [5:0]         hop_q, hop_d;
  logic [4:0]         hsrc_q, hsrc_d;
  logic [4:0]         hdst_q, hdst_d;
  logic [WordW-1:0]   hsv_q, hsv_d;
  logic [WordW-1:0]   hdv_q, hdv_d;
  logic [2*WordW-1:0] prod_q, prod_d;
  logic               zf_q, zf_d, sf_q, sf_d, cf_q, cf_d;
  logic [WordW-1:0]   addr_q, addr_d;
  logic [WordW-1:0]   wdata_q, wdata_d;
  logic               we_q, we_d;
  logic               halt_q, halt_d;
  logic               m_valid_q;

  logic               accept;
  logic [5:0]         ins_op;
  logic [4:0]         ins_dst, ins_src;
  logic [WordW-1:0]   rd_dv, rd_sv, sp_val;
  rf_wr_t             wr;
  alu_res_t           alu;
  logic               set_flags;

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign ins_op  = s_axis_tdata_i[5:0];
  assign ins_dst = s_axis_tdata_i[10:6];
  assign ins_src = s_axis_tdata_i[15:11];

  mscc_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (wr),
    .rd_a_idx_i (ins_dst[RegIdxW-1:0]),
    .rd_b_idx_i (ins_src[RegIdxW-1:0]),
    .rd_a_o     (rd_dv),
    .rd_b_o     (rd_sv),
    .sp_o       (sp_val)
  );

  mscc_alu u_alu (
    .op_i    (ins_op),
    .shamt_i (ins_src),
    .dv_i    (rd_dv),
    .sv_i    (rd_sv),
    .res_o   (alu)
  );

  always_comb begin
    phase_d = phase_q;
    after_d = after_q;
    ip_d    = ip_q;
    hop_d   = hop_q;
    hsrc_d  = hsrc_q;
    hdst_d  = hdst_q;
    hsv_d   = hsv_q;
    hdv_d   = hdv_q;
    prod_d  = prod_q;
    zf_d    = zf_q;
    sf_d    = sf_q;
    cf_d    = cf_q;
    addr_d  = addr_q;
    wdata_d = wdata_q;
    we_d    = we_q;
    halt_d  = halt_q;
    wr      = '0;
    set_flags = 1'b0;

    if (accept && !halt_q) begin
      unique case (phase_q)
        PH_FETCH: begin
          addr_d  = ip_q;
          we_d    = 1'b0;
          phase_d = PH_WAIT;
          after_d = PH_EXEC;
        end
        PH_WAIT: phase_d = after_q;
        PH_EXEC: begin
          hop_d  = ins_op;
          hdst_d = ins_dst;
          hsrc_d = ins_src;
          hdv_d  = rd_dv;
          hsv_d  = rd_sv;
          wr.en      = 1'b1;
          wr.dst_idx = ins_dst[RegIdxW-1:0];
          wr.src_idx = ins_src[RegIdxW-1:0];
          wr.dst_val = alu.dv;
          wr.src_val = alu.sv;
          set_flags  = 1'b1;
          phase_d    = PH_FETCH;
          if (alu.carry_we) cf_d = alu.carry;
          unique case (op_e'(ins_op))
            OP_LDI: begin
              addr_d  = ip_q + WordW'(1);
              phase_d = PH_WAIT;
              after_d = PH_CONTD;
            end
            OP_ST: begin
              addr_d  = rd_dv;
              wdata_d = rd_sv;
              we_d    = 1'b1;
              ip_d    = ip_q + WordW'(1);
              phase_d = PH_WAIT;
              after_d = PH_FETCH;
            end
            OP_LD: begin
              addr_d  = rd_sv;
              phase_d = PH_WAIT;
              after_d = PH_CONTD;
            end
            OP_MUL: begin
              prod_d  = alu.product;
              phase_d = PH_CONTD;
            end
            OP_JMP: begin
              if (jump_ok(ins_src[3:0], zf_q, sf_q, cf_q)) begin
                if (ins_src[4]) begin
                  addr_d  = ip_q + WordW'(1);
                  phase_d = PH_WAIT;
                  after_d = PH_CONTD;
                end else begin
                  ip_d = rd_dv;
                end
              end else begin
                ip_d = ip_q + (ins_src[4] ? WordW'(2) : WordW'(1));
              end
            end
            OP_ADD, OP_SUB, OP_XCHG, OP_XOR, OP_AND, OP_OR, OP_SHL, OP_SHR, OP_MOV,
            OP_INC, OP_DEC: ip_d = ip_q + WordW'(1);
            OP_CMP: begin
              // flags come from the difference, registers stay
              zf_d = alu.cmp_zero;
              sf_d = alu.cmp_sign;
              set_flags = 1'b0;
              ip_d = ip_q + WordW'(1);
            end
            OP_PSHI: begin
              addr_d      = ip_q + WordW'(1);
              wr.xtra_en  = 1'b1;
              wr.xtra_idx = SpIdx;
              wr.xtra_val = sp_val - WordW'(1);
              phase_d     = PH_WAIT;
              after_d     = PH_CONTD;
            end
            OP_PSH: begin
              addr_d      = sp_val - WordW'(1);
              wdata_d     = rd_dv;
              we_d        = 1'b1;
              wr.xtra_en  = 1'b1;
              wr.xtra_idx = SpIdx;
              wr.xtra_val = sp_val - WordW'(1);
              ip_d        = ip_q + WordW'(1);
              phase_d     = PH_WAIT;
              after_d     = PH_FETCH;
            end
            OP_POP: begin
              addr_d      = sp_val;
              wr.xtra_en  = 1'b1;
              wr.xtra_idx = SpIdx;
              wr.xtra_val = sp_val + WordW'(1);
              phase_d     = PH_WAIT;
              after_d     = PH_CONTD;
            end
            default: begin
              // sti, dbg and unassigned opcodes stop the core
              halt_d    = 1'b1;
              wr.en     = 1'b0;
              set_flags = 1'b0;
              cf_d      = cf_q;
              phase_d   = phase_q;
            end
          endcase
        end
        PH_CONTD: begin
          phase_d    = PH_FETCH;
          wr.en      = 1'b1;
          wr.dst_idx = hdst_q[RegIdxW-1:0];
          wr.src_idx = hsrc_q[RegIdxW-1:0];
          wr.dst_val = hdv_q;
          wr.src_val = hsv_q;
          set_flags  = 1'b1;
          unique case (op_e'(hop_q))
            OP_LDI: begin
              wr.dst_val = s_axis_tdata_i;
              ip_d = ip_q + WordW'(2);
            end
            OP_LD, OP_POP: begin
              wr.dst_val = s_axis_tdata_i;
              ip_d = ip_q + WordW'(1);
            end
            OP_MUL: begin
              wr.xtra_en  = 1'b1;
              wr.xtra_idx = MulHiIdx;
              wr.xtra_val = prod_q[2*WordW-1:WordW];
              wr.dst_val  = prod_q[WordW-1:0];
              ip_d = ip_q + WordW'(1);
            end
            OP_JMP: ip_d = s_axis_tdata_i;
            OP_PSHI: begin
              addr_d  = sp_val;
              wdata_d = s_axis_tdata_i;
              we_d    = 1'b1;
              ip_d    = ip_q + WordW'(2);
              phase_d = PH_WAIT;
              after_d = PH_FETCH;
            end
            default: ;
          endcase
        end
        default: phase_d = PH_FETCH;
      endcase
    end

    if (set_flags) begin
      zf_d = (wr.dst_val == '0);
      sf_d = wr.dst_val[WordW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FETCH;
      after_q   <= PH_FETCH;
      ip_q      <= '0;
      hop_q     <= '0;
      hsrc_q    <= '0;
      hdst_q    <= '0;
      hsv_q     <= '0;
      hdv_q     <= '0;
      prod_q    <= '0;
      zf_q      <= 1'b0;
      sf_q      <= 1'b0;
      cf_q      <= 1'b0;
      addr_q    <= '0;
      wdata_q   <= '0;
      we_q      <= 1'b0;
      halt_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      after_q <= after_d;
      ip_q    <= ip_d;
      hop_q   <= hop_d;
      hsrc_q  <= hsrc_d;
      hdst_q  <= hdst_d;
      hsv_q   <= hsv_d;
      hdv_q   <= hdv_d;
      prod_q  <= prod_d;
      zf_q    <= zf_d;
      sf_q    <= sf_d;
      cf_q    <= cf_d;
      addr_q  <= addr_d;
      wdata_q <= wdata_d;
      we_q    <= we_d;
      halt_q  <= halt_d;
      // the request registers are the result item, held until taken
      if (accept) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'b0, halt_q, we_q, wdata_q, addr_q};

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag dropped");

  a_halt_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> $stable(addr_q) && $stable(wdata_q) && $stable(we_q) && $stable(ip_q))
    else $error("halted core changed its request");

  a_no_accept_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(phase_q) && $stable(ip_q) && $stable(addr_q))
    else $error("state moved without an item");

  a_write_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(we_q) |-> $past(phase_q) == PH_EXEC || $past(phase_q) == PH_CONTD)
    else $error("memory write raised outside execute or continue");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_valid_q)
    else $error("accepted item gave no result");

endmodule

FILE: tb/core_req_checker.sv
// checker for the multicycle core: tracks core state from input items and compares memory requests
module core_req_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [15:0]      in_word_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [39:0]      out_data_i,
  output mscc_pkg::phase_e core_phase_o,
  output int               pending_o,
  output int               fail_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mscc_pkg::*;

  // laid out as on the result bus, mem_addr in the lowest bits
  typedef struct packed {
    logic        halted;
    logic        we;
    logic [15:0] wdata;
    logic [15:0] addr;
  } mem_req_t;

  logic [15:0] regs [NumReg];
  logic [15:0] ip;
  phase_e      ph;
  phase_e      ph_after;
  logic [5:0]  held_op;
  logic [4:0]  held_dst;
  logic [4:0]  held_src;
  logic [15:0] held_dv;
  logic [15:0] held_sv;
  logic [31:0] prod;
  logic        zf;
  logic        sf;
  logic        cf;
  logic [15:0] addr_q;
  logic [15:0] wdata_q;
  logic        we_q;
  logic        halt_q;

  mem_req_t    expected_req[$];

  task automatic clear_core();
    for (int i = 0; i < NumReg; i++) regs[i] = '0;
    ip       = '0;
    ph       = PH_FETCH;
    ph_after = PH_FETCH;
    held_op  = '0;
    held_dst = '0;
    held_src = '0;
    held_dv  = '0;
    held_sv  = '0;
    prod     = '0;
    zf       = 1'b0;
    sf       = 1'b0;
    cf       = 1'b0;
    addr_q   = '0;
    wdata_q  = '0;
    we_q     = 1'b0;
    halt_q   = 1'b0;
  endtask

  function automatic bit cond_met(input logic [3:0] code);
    bit ok;
    case (code)
      JC_ALWAYS: ok = 1'b1;
      JC_CARRY:  ok = cf;
      JC_LT:     ok = sf;
      JC_LE:     ok = sf | zf;
      JC_GT:     ok = !sf && !zf;
      JC_GE:     ok = !sf;
      JC_EQ:     ok = zf;
      JC_NE:     ok = !zf;
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  // dst first, then src, so src wins on the same register
  task automatic commit_regs(input logic [15:0] dv, input logic [15:0] sv, input bit upd);
    regs[held_dst[2:0]] = dv;
    regs[held_src[2:0]] = sv;
    if (upd) begin
      zf = (dv == 16'h0);
      sf = dv[15];
    end
  endtask

  task automatic go_wait(input phase_e nxt);
    ph       = PH_WAIT;
    ph_after = nxt;
  endtask

  task automatic exec_instr(input logic [15:0] w);
    logic [5:0]  op;
    logic [4:0]  d;
    logic [4:0]  s;
    logic [15:0] dv;
    logic [15:0] sv;
    logic [15:0] t;
    logic [16:0] wide;
    bit          upd;
    op  = w[5:0];
    d   = w[10:6];
    s   = w[15:11];
    upd = 1'b1;
    held_op  = op;
    held_dst = d;
    held_src = s;
    dv = regs[d[2:0]];
    sv = regs[s[2:0]];
    held_dv = dv;
    held_sv = sv;
    case (op)
      OP_LDI: begin
        addr_q = ip + 16'd1;
        go_wait(PH_CONTD);
      end
      OP_ST: begin
        addr_q  = dv;
        wdata_q = sv;
        we_q    = 1'b1;
        ip      = ip + 16'd1;
        go_wait(PH_FETCH);
      end
      OP_LD: begin
        addr_q = sv;
        go_wait(PH_CONTD);
      end
      OP_ADD: begin
        wide = {1'b0, dv} + {1'b0, sv};
        dv   = wide[15:0];
        cf   = wide[16];
        ip   = ip + 16'd1;
        ph   = PH_FETCH;
      end
      OP_SUB: begin
        wide = {1'b0, dv} - {1'b0, sv};
        dv   = wide[15:0];
        cf   = wide[16];
        ip   = ip + 16'd1;
        ph   = PH_FETCH;
      end
      OP_MUL: begin
        prod = {16'h0, dv} * {16'h0, sv};
        cf   = 1'b0;
        ph   = PH_CONTD;
      end
      OP_JMP: begin
        if (cond_met(s[3:0])) begin
          if (s[4]) begin
            addr_q = ip + 16'd1;
            go_wait(PH_CONTD);
          end else begin
            ip = dv;
            ph = PH_FETCH;
          end
        end else begin
          // not taken: skip the immediate word too
          ip = ip + (s[4] ? 16'd2 : 16'd1);
          ph = PH_FETCH;
        end
      end
      OP_XCHG: begin
        t  = sv;
        sv = dv;
        dv = t;
        ip = ip + 16'd1;
        ph = PH_FETCH;
      end
      OP_XOR: begin
        dv = dv ^ sv;
        ip = ip + 16'd1;
        ph = PH_FETCH;
      end
      OP_AND: begin
        dv = dv & sv;
        ip = ip + 16'd1;
        ph = PH_FETCH;
      end
      OP_OR: begin
        dv = dv | sv;
        ip = ip + 16'd1;
        ph = PH_FETCH;
      end
      OP_CMP: begin
        wide = {1'b0, dv} - {1'b0, sv};
        zf   = (wide[15:0] == 16'h0);
        sf   = wide[15];
        cf   = wide[16];
        upd  = 1'b0;
        ip   = ip + 16'd1;
        ph   = PH_FETCH;
      end
      OP_SHL: begin
        dv = s[4] ? 16'h0 : dv << s[3:0];
        ip = ip + 16'd1;
        ph = PH_FETCH;
      end
      OP_SHR: begin
        dv = s[4] ? 16'h0 : dv >> s[3:0];
        ip = ip + 16'd1;
        ph = PH_FETCH;
      end
      OP_MOV: begin
        dv = sv;
        ip = ip + 16'd1;
        ph = PH_FETCH;
      end
      OP_INC: begin
        wide = {1'b0, dv} + 17'd1;
        dv   = wide[15:0];
        cf   = wide[16];
        ip   = ip + 16'd1;
        ph   = PH_FETCH;
      end
      OP_DEC: begin
        wide = {1'b0, dv} - 17'd1;
        dv   = wide[15:0];
        cf   = wide[16];
        ip   = ip + 16'd1;
        ph   = PH_FETCH;
      end
      OP_PSHI: begin
        addr_q      = ip + 16'd1;
        regs[SpIdx] = regs[SpIdx] - 16'd1;
        go_wait(PH_CONTD);
      end
      OP_PSH: begin
        addr_q      = regs[SpIdx] - 16'd1;
        wdata_q     = dv;
        we_q        = 1'b1;
        regs[SpIdx] = regs[SpIdx] - 16'd1;
        ip          = ip + 16'd1;
        go_wait(PH_FETCH);
      end
      OP_POP: begin
        addr_q      = regs[SpIdx];
        regs[SpIdx] = regs[SpIdx] + 16'd1;
        go_wait(PH_CONTD);
      end
      default: begin
        halt_q = 1'b1;
      end
    endcase
    if (!halt_q) commit_regs(dv, sv, upd);
  endtask

  task automatic finish_instr(input logic [15:0] w);
    logic [15:0] dv;
    logic [15:0] sv;
    dv = held_dv;
    sv = held_sv;
    ph = PH_FETCH;
    case (held_op)
      OP_LDI: begin
        dv = w;
        ip = ip + 16'd2;
      end
      OP_LD, OP_POP: begin
        dv = w;
        ip = ip + 16'd1;
      end
      OP_MUL: begin
        regs[MulHiIdx] = prod[31:16];
        dv = prod[15:0];
        ip = ip + 16'd1;
      end
      OP_JMP: begin
        ip = w;
      end
      OP_PSHI: begin
        addr_q  = regs[SpIdx];
        wdata_q = w;
        we_q    = 1'b1;
        ip      = ip + 16'd2;
        go_wait(PH_FETCH);
      end
      default: begin
      end
    endcase
    commit_regs(dv, sv, 1'b1);
  endtask

  task automatic advance_core(input logic [15:0] w);
    if (!halt_q) begin
      case (ph)
        PH_FETCH: begin
          addr_q = ip;
          we_q   = 1'b0;
          go_wait(PH_EXEC);
        end
        PH_WAIT:  ph = ph_after;
        PH_EXEC:  exec_instr(w);
        default:  finish_instr(w);
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mem_req_t got;
    mem_req_t want;
    if (!rst_ni) begin
      clear_core();
      expected_req.delete();
      fail_cnt_o = 0;
    end else begin
      // drain first: a result never belongs to the item accepted at the same edge
      if (out_valid_i && out_ready_i) begin
        got = mem_req_t'(out_data_i[33:0]);
        if (expected_req.size() == 0) begin
          $error("memory request %h with none expected", out_data_i);
          fail_cnt_o++;
        end else begin
          want = expected_req.pop_front();
          check_field("mem_addr", want.addr, got.addr);
          check_field("mem_wdata", want.wdata, got.wdata);
          check_field("mem_we", 16'(want.we), 16'(got.we));
          check_field("halted_bad_opcode", 16'(want.halted), 16'(got.halted));
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_core(in_word_i);
        expected_req.push_back('{halt_q, we_q, wdata_q, addr_q});
      end
    end
    pending_o    = expected_req.size();
    core_phase_o = ph;
  end

endmodule

FILE: tb/tb_multicycle_sixteen_bit_cpu_core.sv
// testbench top for the multicycle core: clock, reset, instruction stream and verdict
module tb_multicycle_sixteen_bit_cpu_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mscc_pkg::*;

  localparam int RandPerMode   = 125;
  localparam int QuietLimit    = 2000;
  localparam int HoldOffAfter  = 60;
  localparam int HoldOffCycles = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [15:0] s_data;
  logic        m_valid;
  logic        m_ready;
  logic [39:0] m_data;

  phase_e      core_phase;
  int          pending;
  int          fail_cnt;
  int          src_idle_pct;
  int          snk_stall_pct;
  int          sent_cnt;
  bit          halt_sent;
  logic [15:0] dir_instr[$];
  logic [15:0] dir_data[$];

  op_e ok_ops[20] = '{OP_LDI, OP_ST, OP_LD, OP_ADD, OP_SUB, OP_MUL, OP_JMP, OP_XCHG, OP_XOR,
                      OP_AND, OP_OR, OP_CMP, OP_SHL, OP_SHR, OP_MOV, OP_INC, OP_DEC, OP_PSHI,
                      OP_PSH, OP_POP};

  always #2 clk_i = ~clk_i;

  multicycle_sixteen_bit_cpu_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  core_req_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_word_i    (s_data),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .core_phase_o (core_phase),
    .pending_o    (pending),
    .fail_cnt_o   (fail_cnt)
  );

  function automatic logic [15:0] enc(input op_e op, input logic [4:0] d, input logic [4:0] s);
    return {s, d, op};
  endfunction

  function automatic logic [15:0] pick_data();
    logic [15:0] edges [5];
    edges = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
    if ($urandom_range(99) < 30) return edges[$urandom_range(4)];
    return 16'($urandom);
  endfunction

  // the word offered depends on what the core will do with it on this tick
  task automatic send_tick(input bit stop_core);
    logic [15:0] w;
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    case (core_phase)
      PH_EXEC: begin
        if (stop_core && !halt_sent) begin
          w = 16'($urandom);
          case ($urandom_range(43))
            0:       w[5:0] = OP_STI;
            1:       w[5:0] = OP_DBG;
            default: w[5:0] = 6'($urandom_range(63, 22));
          endcase
          halt_sent = 1'b1;
        end else if (dir_instr.size() != 0) begin
          w = dir_instr.pop_front();
        end else begin
          w = enc(ok_ops[$urandom_range(19)], 5'($urandom), 5'($urandom));
        end
      end
      PH_CONTD: w = (dir_data.size() != 0) ? dir_data.pop_front() : pick_data();
      default:  w = 16'($urandom);
    endcase
    s_valid <= 1'b1;
    s_data  <= w;
    do @(posedge clk_i); while (!s_ready);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    s_valid       = 1'b0;
    s_data        = '0;
    rst_ni        = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    sent_cnt      = 0;
    halt_sent     = 1'b0;

    // flag, carry, wrap and index aliasing corners; jump targets come from these too
    dir_instr = '{enc(OP_LDI, 5'd1, 5'd0), enc(OP_LDI, 5'd2, 5'd0), enc(OP_ADD, 5'd1, 5'd2),
                  enc(OP_JMP, 5'd0, 5'(JC_CARRY)), enc(OP_SUB, 5'd2, 5'd1),
                  enc(OP_MUL, 5'd9, 5'd18), enc(OP_CMP, 5'd2, 5'd3),
                  enc(OP_JMP, 5'd0, {1'b1, JC_LT}), enc(OP_JMP, 5'd5, 5'd2),
                  enc(OP_XCHG, 5'd4, 5'd4), enc(OP_XOR, 5'd1, 5'd2), enc(OP_AND, 5'd2, 5'd31),
                  enc(OP_OR, 5'd6, 5'd3), enc(OP_SHL, 5'd2, 5'd31), enc(OP_SHR, 5'd3, 5'd16),
                  enc(OP_MOV, 5'd5, 5'd7), enc(OP_DEC, 5'd6, 5'd0), enc(OP_INC, 5'd6, 5'd0),
                  enc(OP_PSHI, 5'd0, 5'd0), enc(OP_PSH, 5'd1, 5'd0), enc(OP_POP, 5'd4, 5'd0),
                  enc(OP_ST, 5'd1, 5'd2), enc(OP_LD, 5'd2, 5'd7)};
    dir_data  = '{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000,
                  16'h0001};

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    while (dir_instr.size() != 0) send_tick(1'b0);
    dir_data.delete();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
        default: begin src_idle_pct = 23; snk_stall_pct = 23; end
      endcase
      repeat (RandPerMode) send_tick(1'b0);
    end

    // a halting opcode stops the core for good, so it only comes at the end
    while (!halt_sent) send_tick(1'b1);
    repeat (8) send_tick(1'b0);
    s_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : result_sink
    int hold_left;
    bit held_off;
    m_ready   = 1'b0;
    hold_left = 0;
    held_off  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else if (!held_off && sent_cnt >= HoldOffAfter) begin
        // long hold-off so the core backs up and stops taking items
        held_off  = 1'b1;
        hold_left = HoldOffCycles - 1;
        m_ready  <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: multicycle_sixteen_bit_cpu_core.f
design/mscc_pkg.sv
design/mscc_regfile.sv
design/mscc_alu.sv
design/multicycle_sixteen_bit_cpu_core.sv
tb/core_req_checker.sv
tb/tb_multicycle_sixteen_bit_cpu_core.sv
